// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/trm_pkg.sv =====
// ----------------------------------------------------------------------------
// trm_pkg
// Shared types and constants of the tile run rectangle merger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trm_pkg;

    // Map geometry limits
    localparam int MAX_COLUMNS     = 256;
    localparam int MAX_ROWS        = 256;
    localparam int DEF_MAX_RECTS   = 256;
    localparam int COL_W           = $clog2(MAX_COLUMNS);
    localparam int ROW_W           = $clog2(MAX_ROWS);
    localparam logic [8:0] COL_LIMIT = 9'(MAX_COLUMNS);

    // Opcodes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MAP_COLUMNS  = 2'd0;
    localparam logic [1:0] REG_EMPTY_CODE   = 2'd1;
    localparam logic [1:0] REG_ONE_WAY_CODE = 2'd2;

    // Register reset values
    localparam logic [8:0] RST_MAP_COLUMNS  = 9'd16;
    localparam logic [3:0] RST_EMPTY_CODE   = 4'd0;
    localparam logic [3:0] RST_ONE_WAY_CODE = 4'd2;

    typedef struct packed {
        logic [8:0] map_columns;
        logic [3:0] empty_code;
        logic [3:0] one_way_code;
    } cfg_t;

    // One rectangle table entry
    typedef struct packed {
        logic           one_way;
        logic [8:0]     end_y;
        logic [8:0]     end_x;
        logic [ROW_W-1:0] start_y;
        logic [COL_W-1:0] start_x;
    } rect_t;

    // One result word
    typedef struct packed {
        logic       overflow;
        logic [8:0] total;
        logic       hit;
        rect_t      rect;
    } result_t;

endpackage

// ===== hdl/trm_rect_mem.sv =====
// ----------------------------------------------------------------------------
// trm_rect_mem
// Rectangle table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trm_rect_mem
    import trm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_RECTS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rect_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output rect_t         rd_data
);

    rect_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/trm_merge_ctrl.sv =====
// ----------------------------------------------------------------------------
// trm_merge_ctrl
// Run tracking and table sequencer: cuts rows into runs, then scans the
// table one entry at a time with a single compare unit to merge or append.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module trm_merge_ctrl
    import trm_pkg::*;
#(
    parameter int MAX_RECTS = DEF_MAX_RECTS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_opcode,
    input  logic [3:0] in_tile,
    input  logic [7:0] in_index,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int IW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_RECTS);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RD_WAIT  = 3'd1;
    localparam logic [2:0] S_CLOSE    = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CMP = 3'd4;
    localparam logic [2:0] S_APPEND   = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]       state_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] start_reg;
    logic [3:0]       prev_reg;
    logic             open_reg;
    logic [CW-1:0]    count_reg;
    logic             ovf_reg;
    logic             pend2_reg;
    logic [CW-1:0]    scan_reg;
    logic             hit_reg;

    // Close keys (payload)
    logic [COL_W-1:0] key_sx_reg;
    logic [8:0]       key_ex_reg;
    logic             key_ow_reg;
    logic [ROW_W-1:0] key_row_reg;
    logic [COL_W-1:0] k2_sx_reg;
    logic [8:0]       k2_ex_reg;
    logic             k2_ow_reg;
    rect_t            rect_reg;

    // Push decode
    logic [8:0]       cols_eff;
    logic             close1;
    logic             close2;
    logic             row_end;
    logic             open_n;
    logic [COL_W-1:0] start_n;
    logic [COL_W-1:0] k2_sx_n;
    logic             k2_ow_n;

    logic             in_fire;
    logic             hit_n;
    logic             match;
    logic             room;
    logic [CW-1:0]    scan_inc;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    rect_t            wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    rect_t            rd_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign res_valid = (state_reg == S_DONE);
    assign hit_n     = (IW'(in_index) < IW'(count_reg));
    assign room      = (count_reg < COUNT_MAX);
    assign scan_inc  = scan_reg + 1'b1;

    // Clamp the row length and work out which runs a pushed tile closes
    always_comb
    begin
        cols_eff = cfg.map_columns;
        if (cols_eff == 9'd0)
        begin
            cols_eff = 9'd1;
        end
        else if (cols_eff > COL_LIMIT)
        begin
            cols_eff = COL_LIMIT;
        end

        close1  = open_reg && ((in_tile == cfg.empty_code) || (in_tile != prev_reg));
        open_n  = open_reg;
        start_n = start_reg;
        if (in_tile == cfg.empty_code)
        begin
            open_n = 1'b0;
        end
        else if (!open_reg || (in_tile != prev_reg))
        begin
            start_n = col_reg;
            open_n  = 1'b1;
        end

        row_end = (({1'b0, col_reg} + 9'd1) >= cols_eff);
        close2  = row_end && open_n;
        k2_sx_n = start_n;
        k2_ow_n = (in_tile == cfg.one_way_code);
    end

    // Shared compare unit: open rectangle ending on this row with same span
    assign match = !rd_data.one_way && (rd_data.start_x == key_sx_reg) &&
                   (rd_data.end_x == key_ex_reg) && (rd_data.end_y == {1'b0, key_row_reg});

    // Table port selection
    always_comb
    begin
        wr_en   = ((state_reg == S_SCAN_CMP) && match) || ((state_reg == S_APPEND) && room);
        wr_addr = (state_reg == S_SCAN_CMP) ? scan_reg[AW-1:0] : count_reg[AW-1:0];
        if (state_reg == S_SCAN_CMP)
        begin
            wr_data       = rd_data;
            wr_data.end_y = {1'b0, key_row_reg} + 9'd1;
        end
        else
        begin
            wr_data.one_way = key_ow_reg;
            wr_data.end_y   = {1'b0, key_row_reg} + 9'd1;
            wr_data.end_x   = key_ex_reg;
            wr_data.start_y = key_row_reg;
            wr_data.start_x = key_sx_reg;
        end
        rd_en   = (in_fire && (in_opcode == OP_READ)) || (state_reg == S_SCAN_RD);
        rd_addr = (state_reg == S_SCAN_RD) ? scan_reg[AW-1:0] : AW'(in_index);
    end

    trm_rect_mem #(
        .DEPTH (MAX_RECTS),
        .AW    (AW)
    ) u_rect_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer and map state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            start_reg <= '0;
            prev_reg  <= RST_EMPTY_CODE;
            open_reg  <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend2_reg <= 1'b0;
            scan_reg  <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        hit_reg <= 1'b0;
                        case (in_opcode)
                            OP_PUSH:
                            begin
                                if (row_end)
                                begin
                                    open_reg  <= 1'b0;
                                    prev_reg  <= cfg.empty_code;
                                    start_reg <= '0;
                                    col_reg   <= '0;
                                    row_reg   <= row_reg + 1'b1;
                                end
                                else
                                begin
                                    open_reg  <= open_n;
                                    prev_reg  <= in_tile;
                                    start_reg <= start_n;
                                    col_reg   <= col_reg + 1'b1;
                                end
                                pend2_reg <= close1 && close2;
                                state_reg <= (close1 || close2) ? S_CLOSE : S_DONE;
                            end
                            OP_READ:
                            begin
                                hit_reg   <= hit_n;
                                state_reg <= S_RD_WAIT;
                            end
                            OP_CLEAR:
                            begin
                                col_reg   <= '0;
                                row_reg   <= '0;
                                start_reg <= '0;
                                prev_reg  <= cfg.empty_code;
                                open_reg  <= 1'b0;
                                count_reg <= '0;
                                ovf_reg   <= 1'b0;
                                state_reg <= S_DONE;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD_WAIT:
                begin
                    state_reg <= S_DONE;
                end
                S_CLOSE:
                begin
                    scan_reg <= '0;
                    if (key_ow_reg || (count_reg == '0))
                    begin
                        state_reg <= S_APPEND;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    if (match)
                    begin
                        pend2_reg <= 1'b0;
                        state_reg <= pend2_reg ? S_CLOSE : S_DONE;
                    end
                    else if (scan_inc == count_reg)
                    begin
                        state_reg <= S_APPEND;
                    end
                    else
                    begin
                        scan_reg  <= scan_inc;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_APPEND:
                begin
                    if (room)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                    pend2_reg <= 1'b0;
                    state_reg <= pend2_reg ? S_CLOSE : S_DONE;
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Close keys and read result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rect_reg    <= '0;
            key_row_reg <= row_reg;
            k2_sx_reg   <= k2_sx_n;
            k2_ex_reg   <= cols_eff;
            k2_ow_reg   <= k2_ow_n;
            if (close1)
            begin
                key_sx_reg <= start_reg;
                key_ex_reg <= {1'b0, col_reg};
                key_ow_reg <= (prev_reg == cfg.one_way_code);
            end
            else
            begin
                key_sx_reg <= k2_sx_n;
                key_ex_reg <= cols_eff;
                key_ow_reg <= k2_ow_n;
            end
        end
        else if ((state_reg == S_RD_WAIT) && hit_reg)
        begin
            rect_reg <= rd_data;
        end
        else if (pend2_reg && (((state_reg == S_SCAN_CMP) && match) ||
                               (state_reg == S_APPEND)))
        begin
            // advance to the run closed at the row end
            key_sx_reg <= k2_sx_reg;
            key_ex_reg <= k2_ex_reg;
            key_ow_reg <= k2_ow_reg;
        end
    end

    assign res.overflow = ovf_reg;
    assign res.total    = 9'(count_reg);
    assign res.hit      = hit_reg;
    assign res.rect     = rect_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_MAX, "rectangle count beyond table depth")
    `ASSERT_IMPLIES(a_ovf_full, ovf_reg, count_reg == COUNT_MAX, "overflow with free table space")
    `ASSERT_IMPLIES(a_scan_range, state_reg == S_SCAN_CMP, scan_reg < count_reg, "scan past count")
    `ASSERT_NEXT(a_busy_after_accept, in_fire, state_reg != S_IDLE, "idle right after accept")

endmodule

// ===== hdl/tile_run_rectangle_merger.sv =====
// ----------------------------------------------------------------------------
// tile_run_rectangle_merger
// Builds a table of collision rectangles from tile codes pushed row by row.
// ----------------------------------------------------------------------------
// Each accepted word is one command: push a tile, read a rectangle, or clear
// the map; each gives exactly one result word carrying the rectangle (zero
// unless a valid read), the rectangle count and the sticky overflow flag.
// A push closes at most two runs. For each, the merge search compares the
// table entries in turn, up to the rectangle count, and merges into the first
// match or else appends; a one-way run or an empty table goes straight to the
// append. The search walks the table through its single read port with one
// shared compare unit. A result waits in an output register, so the next
// command can start meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_run_rectangle_merger
    import trm_pkg::*;
#(
    parameter int MAX_RECTS = DEF_MAX_RECTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [8:0]  cfg_wdata,
    // Command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // tile_code[3:0], read_index[11:4], zero
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // rect_start_x[7:0], rect_start_y[15:8], rect_end_x[24:16], rect_end_y[33:25],
    // rect_one_way[34], rect_total[43:35], table_overflow[44], zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser    // rect_valid[0]
);

    cfg_t    cfg_reg;
    logic    m_valid_reg;
    result_t m_data_reg;
    logic    res_valid;
    logic    res_ready;
    result_t res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_columns  <= RST_MAP_COLUMNS;
            cfg_reg.empty_code   <= RST_EMPTY_CODE;
            cfg_reg.one_way_code <= RST_ONE_WAY_CODE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_MAP_COLUMNS:  cfg_reg.map_columns  <= cfg_wdata;
                REG_EMPTY_CODE:   cfg_reg.empty_code   <= cfg_wdata[3:0];
                REG_ONE_WAY_CODE: cfg_reg.one_way_code <= cfg_wdata[3:0];
                default:          ;
            endcase
        end
    end

    trm_merge_ctrl #(
        .MAX_RECTS (MAX_RECTS)
    ) u_merge_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (s_axis_tuser),
        .in_tile   (s_axis_tdata[3:0]),
        .in_index  (s_axis_tdata[11:4]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: take a new word when empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_data_reg.hit;
    assign m_axis_tdata  = {3'b000, m_data_reg.overflow, m_data_reg.total,
                            m_data_reg.rect.one_way, m_data_reg.rect.end_y,
                            m_data_reg.rect.end_x, m_data_reg.rect.start_y,
                            m_data_reg.rect.start_x};

endmodule
